### hw/rtl/wfd_pkg.sv
// Package for the wall-follow drive controller: field widths, word and
// register structs, register indexes, drive mode codes and reset values.
// No dependencies.
package wfd_pkg;

  // Fixed field widths
  localparam int DIST_W   = 9;
  localparam int TGT_W    = 6;
  localparam int GAIN_W   = 8;
  localparam int SPEED_W  = 8;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  // Datapath widths
  localparam int ERR_W  = 10;  // target - distance
  localparam int DIFF_W = 11;  // e - prev
  localparam int PP_W   = 19;  // kp * e
  localparam int PDD_W  = 20;  // kd * d
  localparam int SUM_W  = 21;  // kp*e + kd*d
  localparam int SPD_W  = 22;  // base +/- corr

  localparam int GAIN_FRAC_BITS_DEF = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEFT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP_LEFT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KP_RIGHT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_THR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd7;

  // Drive modes
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd2;

  // Speeds
  localparam logic [SPEED_W-1:0] FREE_RUN_SPEED = 8'd160;
  localparam logic [SPEED_W-1:0] A_OFFSET       = 8'd5;

  // Register reset values
  localparam logic [SPEED_W-1:0] RST_BASE_SPEED   = 8'd150;
  localparam logic [TGT_W-1:0]   RST_TARGET_LEFT  = 6'd8;
  localparam logic [TGT_W-1:0]   RST_TARGET_RIGHT = 6'd5;
  localparam logic [GAIN_W-1:0]  RST_KP_LEFT      = 8'd24;
  localparam logic [GAIN_W-1:0]  RST_KP_RIGHT     = 8'd16;
  localparam logic [GAIN_W-1:0]  RST_KD_GAIN      = 8'd8;
  localparam logic [TGT_W-1:0]   RST_FOLLOW_THR   = 6'd3;
  localparam logic [SPEED_W-1:0] RST_SPEED_LIMIT  = 8'd170;

  typedef struct packed {
    logic [DIST_W-1:0] left_cm;
    logic [DIST_W-1:0] right_cm;
  } in_word_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_a;
    logic [SPEED_W-1:0] speed_b;
    logic [MODE_W-1:0]  drive_mode;
  } out_word_t;

  typedef struct packed {
    logic [SPEED_W-1:0] base_speed;
    logic [TGT_W-1:0]   target_left;
    logic [TGT_W-1:0]   target_right;
    logic [GAIN_W-1:0]  kp_left;
    logic [GAIN_W-1:0]  kp_right;
    logic [GAIN_W-1:0]  kd_gain;
    logic [TGT_W-1:0]   follow_threshold;
    logic [SPEED_W-1:0] speed_limit;
  } cfg_t;

  // Error history update from the datapath
  typedef struct packed {
    logic             upd_left;
    logic             upd_right;
    logic [ERR_W-1:0] err;
  } err_upd_t;

endpackage

### hw/rtl/wall_follow_drive_controller_core.sv
// Wall-follow PD drive controller. An accepted word goes into the input register,
// then through the combinational PD datapath into the result register; a stalled
// result holds the next word in the input register.
// Throughput: one word per cycle while the output is not stalled; the PD datapath and its
// error-history feedback set that figure. Synchronous reset clears both
// valid stages and the error history and loads the register defaults.
module wall_follow_drive_controller_core #(
  parameter int GAIN_FRAC_BITS = wfd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  wfd_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output wfd_pkg::out_word_t            out_data,
  input  logic                          cfg_we,
  input  logic [wfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wfd_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  wfd_pkg::cfg_t      cfg;
  wfd_pkg::in_word_t  in_word_r;
  logic               in_valid_r;
  wfd_pkg::out_word_t out_word_r;
  wfd_pkg::out_word_t res_nxt;
  logic               out_valid_r;
  wfd_pkg::err_upd_t  upd;
  logic [wfd_pkg::ERR_W-1:0] prev_left_r;
  logic [wfd_pkg::ERR_W-1:0] prev_right_r;
  logic               advance;
  logic               in_take;

  wfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wfd_pd_datapath #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_pd (
    .cfg        (cfg),
    .word_in    (in_word_r),
    .prev_left  (prev_left_r),
    .prev_right (prev_right_r),
    .word_out   (res_nxt),
    .upd        (upd)
  );

  // Stage handshake
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= res_nxt;
    end
  end

  // Error history of the followed side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_left_r  <= '0;
      prev_right_r <= '0;
    end else if (advance) begin
      if (upd.upd_left) begin
        prev_left_r <= upd.err;
      end
      if (upd.upd_right) begin
        prev_right_r <= upd.err;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

### hw/rtl/wfd_cfg_regs.sv
// Configuration register file of the wall-follow drive controller.
// Depends on wfd_pkg.
module wfd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wfd_pkg::CFG_DAT_W-1:0] cfg_wdata,
  output wfd_pkg::cfg_t                 cfg
);

  wfd_pkg::cfg_t cfg_r;
  wfd_pkg::cfg_t cfg_nxt;

  // Decode one register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        wfd_pkg::REG_BASE_SPEED:   cfg_nxt.base_speed       = cfg_wdata;
        wfd_pkg::REG_TARGET_LEFT:  cfg_nxt.target_left      = cfg_wdata[wfd_pkg::TGT_W-1:0];
        wfd_pkg::REG_TARGET_RIGHT: cfg_nxt.target_right     = cfg_wdata[wfd_pkg::TGT_W-1:0];
        wfd_pkg::REG_KP_LEFT:      cfg_nxt.kp_left          = cfg_wdata;
        wfd_pkg::REG_KP_RIGHT:     cfg_nxt.kp_right         = cfg_wdata;
        wfd_pkg::REG_KD_GAIN:      cfg_nxt.kd_gain          = cfg_wdata;
        wfd_pkg::REG_FOLLOW_THR:   cfg_nxt.follow_threshold = cfg_wdata[wfd_pkg::TGT_W-1:0];
        wfd_pkg::REG_SPEED_LIMIT:  cfg_nxt.speed_limit      = cfg_wdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed       <= wfd_pkg::RST_BASE_SPEED;
      cfg_r.target_left      <= wfd_pkg::RST_TARGET_LEFT;
      cfg_r.target_right     <= wfd_pkg::RST_TARGET_RIGHT;
      cfg_r.kp_left          <= wfd_pkg::RST_KP_LEFT;
      cfg_r.kp_right         <= wfd_pkg::RST_KP_RIGHT;
      cfg_r.kd_gain          <= wfd_pkg::RST_KD_GAIN;
      cfg_r.follow_threshold <= wfd_pkg::RST_FOLLOW_THR;
      cfg_r.speed_limit      <= wfd_pkg::RST_SPEED_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/wfd_pd_datapath.sv
// PD correction and speed clamp for one sensor tick, purely combinational.
// Depends on wfd_pkg.
module wfd_pd_datapath #(
  parameter int GAIN_FRAC_BITS = wfd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wfd_pkg::cfg_t                 cfg,
  input  wfd_pkg::in_word_t             word_in,
  input  logic [wfd_pkg::ERR_W-1:0]     prev_left,
  input  logic [wfd_pkg::ERR_W-1:0]     prev_right,
  output wfd_pkg::out_word_t            word_out,
  output wfd_pkg::err_upd_t             upd
);

  localparam int SUM_W = wfd_pkg::SUM_W;
  // Bias added to a negative sum so the shift truncates toward zero
  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << GAIN_FRAC_BITS) - 1);

  logic                              follow_left;
  logic                              follow_right;
  logic signed [wfd_pkg::ERR_W-1:0]  err_left;
  logic signed [wfd_pkg::ERR_W-1:0]  err_right;
  logic signed [wfd_pkg::ERR_W-1:0]  err_sel;
  logic signed [wfd_pkg::ERR_W-1:0]  prev_sel;
  logic        [wfd_pkg::GAIN_W-1:0] kp_sel;
  logic signed [wfd_pkg::DIFF_W-1:0] diff;
  logic signed [wfd_pkg::PP_W-1:0]   prod_p;
  logic signed [wfd_pkg::PDD_W-1:0]  prod_d;
  logic signed [SUM_W-1:0]           sum;
  logic signed [SUM_W-1:0]           sum_biased;
  logic signed [SUM_W-1:0]           corr;
  logic signed [wfd_pkg::SPD_W-1:0]  base_ext;
  logic signed [wfd_pkg::SPD_W-1:0]  corr_ext;
  logic signed [wfd_pkg::SPD_W-1:0]  raw_a;
  logic signed [wfd_pkg::SPD_W-1:0]  raw_b;
  logic        [wfd_pkg::SPEED_W-1:0] clamp_a;
  logic        [wfd_pkg::SPEED_W-1:0] clamp_b;
  logic        [wfd_pkg::SPEED_W:0]   off_a;

  function automatic logic [wfd_pkg::SPEED_W-1:0] clamp_speed(
    input logic signed [wfd_pkg::SPD_W-1:0] v,
    input logic        [wfd_pkg::SPEED_W-1:0] limit
  );
    logic [wfd_pkg::SPEED_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({{(wfd_pkg::SPD_W-wfd_pkg::SPEED_W){1'b0}}, limit})) begin
      res = limit;
    end else begin
      res = v[wfd_pkg::SPEED_W-1:0];
    end
    return res;
  endfunction

  // Side selection, left wins when both are close
  assign follow_left  = {3'b000, cfg.follow_threshold} > word_in.left_cm;
  assign follow_right = !follow_left && ({3'b000, cfg.follow_threshold} > word_in.right_cm);

  // Errors: target - distance
  assign err_left  = $signed({4'b0000, cfg.target_left})  - $signed({1'b0, word_in.left_cm});
  assign err_right = $signed({4'b0000, cfg.target_right}) - $signed({1'b0, word_in.right_cm});

  assign err_sel  = follow_left ? err_left : err_right;
  assign prev_sel = follow_left ? $signed(prev_left) : $signed(prev_right);
  assign kp_sel   = follow_left ? cfg.kp_left : cfg.kp_right;

  // PD sum
  assign diff   = $signed({err_sel[wfd_pkg::ERR_W-1], err_sel})
                - $signed({prev_sel[wfd_pkg::ERR_W-1], prev_sel});
  assign prod_p = $signed({1'b0, kp_sel}) * err_sel;
  assign prod_d = $signed({1'b0, cfg.kd_gain}) * diff;
  assign sum    = $signed({{2{prod_p[wfd_pkg::PP_W-1]}}, prod_p})
                + $signed({prod_d[wfd_pkg::PDD_W-1], prod_d});

  // Scale down, truncated toward zero
  assign sum_biased = sum[SUM_W-1] ? (sum + $signed(ROUND_BIAS)) : sum;
  assign corr       = sum_biased >>> GAIN_FRAC_BITS;

  assign base_ext = $signed({{(wfd_pkg::SPD_W-wfd_pkg::SPEED_W){1'b0}}, cfg.base_speed});
  assign corr_ext = $signed({corr[SUM_W-1], corr});
  assign raw_a    = follow_left ? (base_ext + corr_ext) : (base_ext - corr_ext);
  assign raw_b    = follow_left ? (base_ext - corr_ext) : (base_ext + corr_ext);

  // Clamp, then offset A with saturation
  assign clamp_a = clamp_speed(raw_a, cfg.speed_limit);
  assign clamp_b = clamp_speed(raw_b, cfg.speed_limit);
  assign off_a   = {1'b0, clamp_a} + {1'b0, wfd_pkg::A_OFFSET};

  always_comb begin
    if (follow_left || follow_right) begin
      word_out.speed_a    = off_a[wfd_pkg::SPEED_W] ? '1 : off_a[wfd_pkg::SPEED_W-1:0];
      word_out.speed_b    = clamp_b;
      word_out.drive_mode = follow_left ? wfd_pkg::MODE_LEFT : wfd_pkg::MODE_RIGHT;
    end else begin
      word_out.speed_a    = wfd_pkg::FREE_RUN_SPEED;
      word_out.speed_b    = wfd_pkg::FREE_RUN_SPEED;
      word_out.drive_mode = wfd_pkg::MODE_FREE;
    end
  end

  assign upd.upd_left  = follow_left;
  assign upd.upd_right = follow_right;
  assign upd.err       = err_sel;

endmodule

### hw/rtl/wfd_checker.sv
// Port-level checks for the wall-follow drive controller, bound to the top.
// Depends on wfd_pkg and wall_follow_drive_controller_core.
module wfd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input wfd_pkg::out_word_t            out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // Every accepted word is followed by a valid output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("accepted word did not reach the output");

  // Free run always drives the fixed speed on both motors
  a_free_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.drive_mode == wfd_pkg::MODE_FREE |->
      out_data.speed_a == wfd_pkg::FREE_RUN_SPEED &&
      out_data.speed_b == wfd_pkg::FREE_RUN_SPEED)
    else $error("free run speeds wrong");

  // Following applies the A offset and never reports an unused mode
  a_follow_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.drive_mode != wfd_pkg::MODE_FREE |->
      (out_data.drive_mode == wfd_pkg::MODE_LEFT ||
       out_data.drive_mode == wfd_pkg::MODE_RIGHT) &&
      out_data.speed_a >= wfd_pkg::A_OFFSET)
    else $error("follow result without offset or bad mode");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind wall_follow_drive_controller_core wfd_checker u_wfd_checker (.*);

### tb/tb_top.sv
// Self-checking bench for wall_follow_drive_controller_core: PD drive prediction,
// register sweeps, random sensor ticks under varied idling and one long output hold-off.
// Depends on wfd_pkg and the core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wfd_pkg::*;

  localparam int GAIN_FRAC   = GAIN_FRAC_BITS_DEF;
  localparam int IDLE_LIMIT  = 5000;   // cycles with no word moving on either side
  localparam int HOLD_CYCLES = 300;    // long output hold-off
  localparam int DRAIN_WAIT  = 4;      // pipeline latency plus margin
  localparam int MAX_PRINTS  = 40;

  // DUT connections; the bench-driven ones are known from time zero
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_word_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_BASE_SPEED;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  // Register copy and error history used for prediction
  logic [SPEED_W-1:0] m_base   = RST_BASE_SPEED;
  logic [TGT_W-1:0]   m_tgt_l  = RST_TARGET_LEFT;
  logic [TGT_W-1:0]   m_tgt_r  = RST_TARGET_RIGHT;
  logic [GAIN_W-1:0]  m_kp_l   = RST_KP_LEFT;
  logic [GAIN_W-1:0]  m_kp_r   = RST_KP_RIGHT;
  logic [GAIN_W-1:0]  m_kd     = RST_KD_GAIN;
  logic [TGT_W-1:0]   m_thr    = RST_FOLLOW_THR;
  logic [SPEED_W-1:0] m_limit  = RST_SPEED_LIMIT;
  logic signed [ERR_W-1:0] hist_l = '0;
  logic signed [ERR_W-1:0] hist_r = '0;

  out_word_t drive_q[$];   // predicted drive words, oldest first

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count     = 0;
  int ticks_in      = 0;
  int words_out     = 0;
  int cfg_writes    = 0;
  int idle_cycles   = 0;
  int hold_gen      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  wall_follow_drive_controller_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // PD drive prediction for one sensor tick; updates the followed side's history
  function automatic out_word_t predict_drive(input in_word_t w);
    out_word_t r;
    int err, prev, corr, sa, sb;
    logic [GAIN_W-1:0] kp;
    r = '0;
    if (w.left_cm < m_thr) begin
      err  = int'(m_tgt_l) - int'(w.left_cm);
      prev = int'(hist_l);
      hist_l = err[ERR_W-1:0];
      kp = m_kp_l;
      r.drive_mode = MODE_LEFT;
    end else if (w.right_cm < m_thr) begin
      err  = int'(m_tgt_r) - int'(w.right_cm);
      prev = int'(hist_r);
      hist_r = err[ERR_W-1:0];
      kp = m_kp_r;
      r.drive_mode = MODE_RIGHT;
    end else begin
      r.speed_a    = FREE_RUN_SPEED;
      r.speed_b    = FREE_RUN_SPEED;
      r.drive_mode = MODE_FREE;
      return r;
    end
    // division on int truncates toward zero
    corr = (int'(kp) * err + int'(m_kd) * (err - prev)) / (1 << GAIN_FRAC);
    if (r.drive_mode == MODE_LEFT) begin
      sa = int'(m_base) + corr;
      sb = int'(m_base) - corr;
    end else begin
      sa = int'(m_base) - corr;
      sb = int'(m_base) + corr;
    end
    sa = (sa < 0) ? 0 : ((sa > int'(m_limit)) ? int'(m_limit) : sa);
    sb = (sb < 0) ? 0 : ((sb > int'(m_limit)) ? int'(m_limit) : sb);
    sa = sa + int'(A_OFFSET);
    if (sa > 255) sa = 255;
    r.speed_a = sa[SPEED_W-1:0];
    r.speed_b = sb[SPEED_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Result checker and input capture, sampled at the rising edge
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        words_out++;
        if (drive_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word a=%0d b=%0d mode=%0d",
                                    out_data.speed_a, out_data.speed_b, out_data.drive_mode));
        end else begin
          want = drive_q.pop_front();
          if (out_data.speed_a !== want.speed_a)
            report_mismatch($sformatf("word %0d speed_a got %0d want %0d",
                                      words_out, out_data.speed_a, want.speed_a));
          if (out_data.speed_b !== want.speed_b)
            report_mismatch($sformatf("word %0d speed_b got %0d want %0d",
                                      words_out, out_data.speed_b, want.speed_b));
          if (out_data.drive_mode !== want.drive_mode)
            report_mismatch($sformatf("word %0d drive_mode got %0d want %0d",
                                      words_out, out_data.drive_mode, want.drive_mode));
        end
      end
      if (in_valid && !in_stall) begin
        ticks_in++;
        drive_q.push_back(predict_drive(in_data));
      end
    end
  end

  // Watchdog on cycles where no word moves
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Receiver stall: random idling, or a counted hold-off when requested
  always @(negedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one tick; called and returns at a falling edge, valid left high
  task automatic send_tick(input logic [DIST_W-1:0] left, input logic [DIST_W-1:0] right);
    in_word_t w;
    w.left_cm  = left;
    w.right_cm = right;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted word has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (drive_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // One register write; leaves cfg_we high so writes can run back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      REG_BASE_SPEED:   m_base  = val;
      REG_TARGET_LEFT:  m_tgt_l = val[TGT_W-1:0];
      REG_TARGET_RIGHT: m_tgt_r = val[TGT_W-1:0];
      REG_KP_LEFT:      m_kp_l  = val;
      REG_KP_RIGHT:     m_kp_r  = val;
      REG_KD_GAIN:      m_kd    = val;
      REG_FOLLOW_THR:   m_thr   = val[TGT_W-1:0];
      REG_SPEED_LIMIT:  m_limit = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Load all eight registers; the block must be idle
  task automatic apply_settings(input logic [7:0] base, input logic [7:0] tl,
                                input logic [7:0] tr, input logic [7:0] kpl,
                                input logic [7:0] kpr, input logic [7:0] kd,
                                input logic [7:0] thr, input logic [7:0] lim);
    write_reg(REG_BASE_SPEED, base);
    write_reg(REG_TARGET_LEFT, tl);
    write_reg(REG_TARGET_RIGHT, tr);
    write_reg(REG_KP_LEFT, kpl);
    write_reg(REG_KP_RIGHT, kpr);
    write_reg(REG_KD_GAIN, kd);
    write_reg(REG_FOLLOW_THR, thr);
    write_reg(REG_SPEED_LIMIT, lim);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // 8-bit value biased toward the ends of the range
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  // Distance inside the follow zone, often right at its edge
  function automatic logic [DIST_W-1:0] near_dist();
    if (m_thr == 0) return DIST_W'($urandom_range(511));
    if ($urandom_range(99) < 15) return DIST_W'(m_thr - 1);
    return DIST_W'($urandom_range(int'(m_thr) - 1));
  endfunction

  // Distance outside the follow zone, often exactly at the threshold
  function automatic logic [DIST_W-1:0] far_dist();
    if ($urandom_range(99) < 15) return DIST_W'(m_thr);
    return DIST_W'($urandom_range(511, int'(m_thr)));
  endfunction

  // Random tick: mostly following, some free run
  task automatic send_random_tick();
    int r;
    r = $urandom_range(99);
    if (r < 35)      send_tick(near_dist(), DIST_W'($urandom_range(511)));
    else if (r < 65) send_tick(far_dist(), near_dist());
    else if (r < 80) send_tick(near_dist(), near_dist());
    else             send_tick(far_dist(), far_dist());
  endtask

  // Reset values of registers and history: each mode, both-near, field extremes
  task automatic test_reset_defaults();
    send_tick(9'd0, 9'd0);
    send_tick(9'd2, 9'd511);
    send_tick(9'd1, 9'd0);
    send_tick(9'd3, 9'd0);
    send_tick(9'd511, 9'd2);
    send_tick(9'd3, 9'd3);
    send_tick(9'd511, 9'd511);
    send_tick(9'd0, 9'd511);
    wait_idle();
  endtask

  // Registers at their extremes: saturation at 255, zero threshold, clamp at zero
  task automatic test_register_extremes();
    apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_tick(9'd0, 9'd0);
    send_tick(9'd62, 9'd0);
    send_tick(9'd63, 9'd0);
    send_tick(9'd63, 9'd62);
    send_tick(9'd511, 9'd511);
    wait_idle();
    apply_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_tick(9'd0, 9'd0);
    send_tick(9'd511, 9'd0);
    wait_idle();
    apply_settings(8'd0, 8'd0, 8'd63, 8'd255, 8'd0, 8'd255, 8'd63, 8'd0);
    send_tick(9'd62, 9'd100);
    send_tick(9'd0, 9'd100);
    send_tick(9'd300, 9'd0);
    send_tick(9'd300, 9'd62);
    wait_idle();
    apply_settings(8'd255, 8'd63, 8'd0, 8'd255, 8'd255, 8'd0, 8'd63, 8'd250);
    send_tick(9'd0, 9'd0);
    send_tick(9'd100, 9'd62);
    wait_idle();
  endtask

  // Random settings and ticks under one idling mix
  task automatic test_random_phase(input int s_pct, input int r_pct, input int blocks,
                                   input int per_block);
    logic [7:0] thr;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int b = 0; b < blocks; b++) begin
      thr = {2'($urandom_range(3)), 6'($urandom_range(63, 1))};
      if ($urandom_range(9) == 0) thr[5:0] = 6'd63;
      apply_settings(pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                     pick_byte(), thr, ($urandom_range(3) == 0) ? pick_byte() :
                                       8'($urandom_range(250)));
      for (int i = 0; i < per_block; i++) send_random_tick();
      wait_idle();
    end
  endtask

  // Long output hold-off while ticks keep coming, so the input backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(8'd128, 8'd30, 8'd30, 8'd40, 8'd40, 8'd20, 8'd40, 8'd200);
    hold_gen++;
    for (int i = 0; i < 40; i++) send_random_tick();
    wait_idle();
  endtask

  initial begin
    send_idle_pct = 18;
    recv_idle_pct = 51;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_random_phase(18, 51, 6, 90);
    test_random_phase(51, 18, 6, 90);
    test_random_phase(0, 0, 6, 90);
    test_backpressure();

    if (drive_q.size() != 0)
      report_mismatch($sformatf("%0d predicted words never came out", drive_q.size()));

    $display("covered %0d ticks and %0d drive words over %0d register writes,",
             ticks_in, words_out, cfg_writes);
    $display("all drive modes, register extremes and a long output hold-off; %0d mismatches",
             err_count);
    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
